// ----- rtl/sesg_pkg.sv -----
// Package for the sorted edge source grouper.
// Holds the item, result and register types, record codes and mask bit positions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sesg_pkg;

   localparam int unsigned MAX_EDGES = 65536;

   localparam int unsigned REQ_DATA_W = 288;
   localparam int unsigned RSP_DATA_W = 264;
   localparam int unsigned RSP_USER_W = 2;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_EDGE_TOTAL     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FORWARD_ID     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSPOSE_ID   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PLACEMENT_ROOM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OWNER_ROOM     = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_PLACE  = 2'd0;
   localparam logic [1:0] KIND_OWNER  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_ARG  = 3'd1;
   localparam logic [2:0] ST_BAD_ORD  = 3'd2;
   localparam logic [2:0] ST_DUP_ID   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_CAPACITY = 3'd5;

   // bit positions in the pending-record mask, emitted lowest first
   localparam int unsigned MB_CLOSE  = 0;
   localparam int unsigned MB_PLACE  = 1;
   localparam int unsigned MB_FINAL  = 2;
   localparam int unsigned MB_STATUS = 3;
   localparam int unsigned MASK_W    = 4;

   typedef struct packed {
      logic [63:0] identity_ident;
      logic [63:0] dst_node;
      logic [63:0] src_node;
      logic [63:0] edge_ident;
      logic [15:0] identity_slot;
      logic [15:0] source_slot;
   } sesg_item_type;

   typedef struct packed {
      logic [3:0]  pad;
      logic [16:0] group_length;
      logic [15:0] group_begin;
      logic [15:0] out_position;
      logic [15:0] owner_number;
      logic [63:0] out_dest;
      logic [63:0] out_source;
      logic [63:0] out_edge;
      logic [2:0]  status;
   } sesg_rsp_type;

   typedef struct packed {
      logic [16:0] edge_total;
      logic [63:0] forward_id;
      logic [63:0] transpose_id;
      logic [16:0] placement_room;
      logic [16:0] owner_room;
   } sesg_cfg_type;

   // all records one item causes
   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [2:0]        code;
      logic [63:0]       prev_src;
      logic [15:0]       prev_owner;
      logic [15:0]       prev_begin;
      logic [16:0]       prev_len;
      logic [63:0]       edge_id;
      logic [63:0]       src;
      logic [63:0]       dst;
      logic [15:0]       owner;
      logic [15:0]       pos;
      logic [15:0]       fin_begin;
      logic [16:0]       fin_len;
   } sesg_bundle_type;

endpackage

`default_nettype wire

// ----- rtl/sesg_track.sv -----
// Order checker and run tracker: holds the previous edge, counters and error code,
// and builds the record bundle for the registered item. Depends on sesg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sesg_track (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sesg_pkg::sesg_cfg_type   cfg,
   input  wire sesg_pkg::sesg_item_type  item,
   input  wire logic                     go,
   output sesg_pkg::sesg_bundle_type     bundle
);
   import sesg_pkg::*;

   logic [63:0] prev_source_ff, prev_source_in;
   logic [63:0] prev_dest_ff, prev_dest_in;
   logic [63:0] prev_edge_ff, prev_edge_in;
   logic [63:0] prev_identity_ff, prev_identity_in;
   logic [16:0] position_count_ff, position_count_in;
   logic [16:0] owner_tally_ff, owner_tally_in;
   logic [15:0] run_begin_ff, run_begin_in;
   logic [16:0] run_length_ff, run_length_in;
   logic [2:0]  error_code_ff, error_code_in;

   logic        cfg_bad;
   logic        past_end;
   logic        slot_bad;
   logic        zero_bad;
   logic        first;
   logic        less;
   logic        new_run;
   logic        fin;
   logic        cap_bad;
   logic        ok;
   logic [16:0] owners_after;
   logic [16:0] len_base;

   always_comb begin
      cfg_bad = (cfg.edge_total == '0)
         || (32'(cfg.edge_total) > 32'(MAX_EDGES))
         || (cfg.forward_id == '0) || (cfg.transpose_id == '0)
         || (cfg.forward_id == cfg.transpose_id);
      past_end = position_count_ff >= cfg.edge_total;
      slot_bad = ({1'b0, item.source_slot} >= cfg.edge_total)
         || ({1'b0, item.identity_slot} >= cfg.edge_total);
      zero_bad = (item.edge_ident == '0) || (item.src_node == '0)
         || (item.dst_node == '0);
      first = position_count_ff == '0;
      if (prev_source_ff != item.src_node) begin
         less = prev_source_ff < item.src_node;
      end else if (prev_dest_ff != item.dst_node) begin
         less = prev_dest_ff < item.dst_node;
      end else begin
         less = prev_edge_ff < item.edge_ident;
      end
      new_run = first || (prev_source_ff != item.src_node);
      fin = ({1'b0, position_count_ff} + 18'd1) == {1'b0, cfg.edge_total};
      owners_after = owner_tally_ff + {16'd0, new_run};
      cap_bad = (cfg.edge_total > cfg.placement_room) || (owners_after > cfg.owner_room);
      len_base = new_run ? 17'd0 : run_length_ff;

      bundle = '0;
      ok = 1'b0;
      if (error_code_ff != ST_OK) begin
         bundle.mask = '0;
      end else if (cfg_bad) begin
         bundle.mask[MB_STATUS] = 1'b1;
         bundle.code = ST_BAD_ARG;
      end else if (past_end) begin
         bundle.mask = '0;
      end else if (slot_bad) begin
         bundle.mask[MB_STATUS] = 1'b1;
         bundle.code = ST_BAD_ORD;
      end else if (zero_bad) begin
         bundle.mask[MB_STATUS] = 1'b1;
         bundle.code = ST_BAD_ARG;
      end else if (!first && !less) begin
         bundle.mask[MB_STATUS] = 1'b1;
         bundle.code = (prev_edge_ff == item.edge_ident) ? ST_DUP_ID : ST_BAD_ORD;
      end else if (!first && (prev_identity_ff >= item.identity_ident)) begin
         bundle.mask[MB_STATUS] = 1'b1;
         bundle.code = (prev_identity_ff == item.identity_ident) ? ST_DUP_ID : ST_BAD_ORD;
      end else if (fin && cap_bad) begin
         bundle.mask[MB_STATUS] = 1'b1;
         bundle.code = ST_CAPACITY;
      end else begin
         ok = 1'b1;
         bundle.mask[MB_CLOSE] = new_run && !first;
         bundle.mask[MB_PLACE] = 1'b1;
         bundle.mask[MB_FINAL] = fin;
      end
      bundle.prev_src   = prev_source_ff;
      bundle.prev_owner = 16'(owner_tally_ff - 17'd1);
      bundle.prev_begin = run_begin_ff;
      bundle.prev_len   = run_length_ff;
      bundle.edge_id    = item.edge_ident;
      bundle.src        = item.src_node;
      bundle.dst        = item.dst_node;
      bundle.owner      = 16'(owners_after - 17'd1);
      bundle.pos        = position_count_ff[15:0];
      bundle.fin_begin  = new_run ? position_count_ff[15:0] : run_begin_ff;
      bundle.fin_len    = len_base + 17'd1;
   end

   always_comb begin
      prev_source_in    = prev_source_ff;
      prev_dest_in      = prev_dest_ff;
      prev_edge_in      = prev_edge_ff;
      prev_identity_in  = prev_identity_ff;
      position_count_in = position_count_ff;
      owner_tally_in    = owner_tally_ff;
      run_begin_in      = run_begin_ff;
      run_length_in     = run_length_ff;
      error_code_in     = error_code_ff;
      if (go) begin
         if (bundle.mask[MB_STATUS]) begin
            error_code_in = bundle.code;
         end
         if (ok) begin
            prev_source_in    = item.src_node;
            prev_dest_in      = item.dst_node;
            prev_edge_in      = item.edge_ident;
            prev_identity_in  = item.identity_ident;
            position_count_in = position_count_ff + 17'd1;
            owner_tally_in    = owners_after;
            run_begin_in      = bundle.fin_begin;
            run_length_in     = bundle.fin_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_source_ff    <= '0;
         prev_dest_ff      <= '0;
         prev_edge_ff      <= '0;
         prev_identity_ff  <= '0;
         position_count_ff <= '0;
         owner_tally_ff    <= '0;
         run_begin_ff      <= '0;
         run_length_ff     <= '0;
         error_code_ff     <= ST_OK;
      end else begin
         prev_source_ff    <= prev_source_in;
         prev_dest_ff      <= prev_dest_in;
         prev_edge_ff      <= prev_edge_in;
         prev_identity_ff  <= prev_identity_in;
         position_count_ff <= position_count_in;
         owner_tally_ff    <= owner_tally_in;
         run_begin_ff      <= run_begin_in;
         run_length_ff     <= run_length_in;
         error_code_ff     <= error_code_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sesg_emit.sv -----
// Result register: holds one item's record bundle and sends its records one
// transfer at a time, lowest mask bit first. Depends on sesg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sesg_emit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sesg_pkg::sesg_bundle_type         bundle,
   input  wire logic                              load,
   output logic                                   free,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sesg_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // status, out_edge, out_source,
                                                              // out_dest, owner_number,
                                                              // out_position, group_begin,
                                                              // group_length
   output logic [sesg_pkg::RSP_USER_W-1:0]        rsp_tuser,  // kind
   output logic                                   rsp_tlast
);
   import sesg_pkg::*;

   logic [MASK_W-1:0] mask_ff, mask_in;
   sesg_bundle_type   data_ff, data_in;
   logic [MASK_W-1:0] lowest;
   logic [MASK_W-1:0] mask_after;
   logic              pop;
   sesg_rsp_type      rsp;

   always_comb begin
      lowest     = mask_ff & (~mask_ff + MASK_W'(1));
      mask_after = mask_ff & ~lowest;
      pop        = rsp_tvalid && rsp_tready;
      free       = (mask_ff == '0) || (pop && (mask_after == '0));
      mask_in    = pop ? mask_after : mask_ff;
      data_in    = data_ff;
      if (load) begin
         mask_in = bundle.mask;
         data_in = bundle;
      end
   end

   always_comb begin
      rsp       = '0;
      rsp_tuser = KIND_PLACE;
      rsp_tlast = 1'b0;
      if (lowest[MB_CLOSE]) begin
         rsp_tuser          = KIND_OWNER;
         rsp.out_source     = data_ff.prev_src;
         rsp.owner_number   = data_ff.prev_owner;
         rsp.group_begin    = data_ff.prev_begin;
         rsp.group_length   = data_ff.prev_len;
      end else if (lowest[MB_PLACE]) begin
         rsp_tuser          = KIND_PLACE;
         rsp.out_edge       = data_ff.edge_id;
         rsp.out_source     = data_ff.src;
         rsp.out_dest       = data_ff.dst;
         rsp.owner_number   = data_ff.owner;
         rsp.out_position   = data_ff.pos;
      end else if (lowest[MB_FINAL]) begin
         rsp_tuser          = KIND_OWNER;
         rsp_tlast          = 1'b1;
         rsp.out_source     = data_ff.src;
         rsp.owner_number   = data_ff.owner;
         rsp.group_begin    = data_ff.fin_begin;
         rsp.group_length   = data_ff.fin_len;
      end else if (lowest[MB_STATUS]) begin
         rsp_tuser          = KIND_STATUS;
         rsp_tlast          = 1'b1;
         rsp.status         = data_ff.code;
      end
      rsp_tvalid = mask_ff != '0;
      rsp_tdata  = rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ----- rtl/sorted_edge_source_grouper_unit.sv -----
// Top level of the sorted edge source grouper: register port, input register,
// tracker and result register. Depends on sesg_pkg, sesg_track, sesg_emit.
//
//  port group | dir | payload                                       | transfer
//  req_       | in  | tdata: item fields, 288 bits                  | tvalid & tready
//  rsp_       | out | tdata: record fields; tuser: kind; tlast: last | tvalid & tready
//  csr_       | in  | csr_index, csr_wdata (64 bits)                | csr_we
//
// An item is checked from the input register after its transfer, and its records
// land in the result register. A new item is taken every cycle while each item
// yields one record and rsp_ does not stall; an item with two or three records
// holds the input until the single result register, draining one record a cycle,
// sends its last. Synchronous active-high reset clears counters and error; registers
// return to their defaults. Stalls on rsp_ back up into req_tready with no loss.
`timescale 1ns / 1ps
`default_nettype none

module sorted_edge_source_grouper_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [sesg_pkg::REQ_DATA_W-1:0]      req_tdata,  // source_slot, identity_slot,
                                                                 // edge_ident, src_node,
                                                                 // dst_node, identity_ident
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [sesg_pkg::RSP_DATA_W-1:0]           rsp_tdata,  // status, out_edge, out_source,
                                                                 // out_dest, owner_number,
                                                                 // out_position, group_begin,
                                                                 // group_length
   output logic [sesg_pkg::RSP_USER_W-1:0]           rsp_tuser,  // kind
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_we,
   input  wire logic [sesg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sesg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sesg_pkg::*;

   sesg_cfg_type    cfg_ff, cfg_in;
   logic            in_valid_ff, in_valid_in;
   sesg_item_type   item_ff, item_in;
   sesg_bundle_type bundle;
   logic            emit_free;
   logic            go;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_EDGE_TOTAL:     cfg_in.edge_total     = csr_wdata[16:0];
            REG_FORWARD_ID:     cfg_in.forward_id     = csr_wdata;
            REG_TRANSPOSE_ID:   cfg_in.transpose_id   = csr_wdata;
            REG_PLACEMENT_ROOM: cfg_in.placement_room = csr_wdata[16:0];
            REG_OWNER_ROOM:     cfg_in.owner_room     = csr_wdata[16:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      go          = in_valid_ff && emit_free;
      req_tready  = !in_valid_ff || go;
      in_valid_in = in_valid_ff && !go;
      item_in     = item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         item_in     = sesg_item_type'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edge_total     <= 17'd1;
         cfg_ff.forward_id     <= '0;
         cfg_ff.transpose_id   <= '0;
         cfg_ff.placement_room <= 17'd65536;
         cfg_ff.owner_room     <= 17'd65536;
         in_valid_ff           <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      item_ff <= item_in;
   end

   sesg_track u_track (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .item   (item_ff),
      .go     (go),
      .bundle (bundle)
   );

   sesg_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .load       (go),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_silent_after_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser == KIND_STATUS) |=> !rsp_tvalid)
      else $error("result sent after status");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_OWNER || rsp_tuser == KIND_STATUS))
      else $error("last on placement record");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_STATUS) |-> rsp_tlast)
      else $error("status record without last");

endmodule

`default_nettype wire

// ----- test/tb_sorted_edge_source_grouper_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sorted_edge_source_grouper_unit: streams ascending edge lists
// through the req_ channel and checks every rsp_ transfer against an in-bench grouping model.
// Depends on sesg_pkg and the RTL top level.

module tb_sorted_edge_source_grouper_unit;
   import sesg_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS   = 35;
   localparam logic [63:0] ALL_ONES      = '1;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [63:0] edge_id;
      logic [63:0] src;
      logic [63:0] dst;
      logic [15:0] owner;
      logic [15:0] pos;
      logic [15:0] grp_begin;
      logic [16:0] grp_len;
      logic        last;
   } record_type;

   typedef enum int {
      END_FINAL, END_CAPACITY, END_BAD_REG, END_SLOT, END_ZERO, END_ORDER, END_IDENT
   } ending_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // register mirror
   logic [16:0] cfg_total      = 17'd1;
   logic [63:0] cfg_forward    = '0;
   logic [63:0] cfg_transpose  = '0;
   logic [16:0] cfg_place_room = 17'd65536;
   logic [16:0] cfg_owner_room = 17'd65536;

   // grouping state
   logic [63:0] last_src    = '0;
   logic [63:0] last_dst    = '0;
   logic [63:0] last_edge   = '0;
   logic [63:0] last_ident  = '0;
   logic [16:0] pos_count   = '0;
   logic [16:0] owner_tally = '0;
   logic [15:0] run_begin   = '0;
   logic [16:0] run_len     = '0;
   logic [2:0]  err_code    = ST_OK;
   record_type  record_q[$];

   // edge list generator state
   logic [63:0] gen_src     = '0;
   logic [63:0] gen_dst     = '0;
   logic [63:0] gen_edge    = '0;
   logic [63:0] gen_ident   = '0;
   bit          gen_started = 1'b0;

   sesg_item_type stimulus_q[$];
   sesg_item_type offer_item = '0;
   bit            offering   = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned send_pct_tab[4] = '{0, 87, 0, 28};
   int unsigned recv_pct_tab[4] = '{0, 0, 87, 28};

   int unsigned fault_count     = 0;
   int unsigned accepted_count  = 0;
   int unsigned result_count    = 0;
   int unsigned place_rec_count = 0;
   int unsigned owner_rec_count = 0;
   int unsigned cycle_count     = 0;

   sorted_edge_source_grouper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_wide();
      int unsigned pick;
      logic [63:0] value;
      pick = $urandom_range(0, 9);
      value = rand64();
      if (pick == 0) value = 64'd1;
      else if (pick == 1) value = ALL_ONES;
      if (value == '0) value = 64'd1;
      return value;
   endfunction

   // step upward, leaving room for later steps
   function automatic logic [63:0] climb(input logic [63:0] from, input logic [63:0] share);
      return from + 64'd1 + rand64() % ((ALL_ONES - from) / share + 64'd1);
   endfunction

   function automatic logic [63:0] room_value();
      int unsigned pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return 64'd0;
      if (pick == 1) return 64'd65536;
      return 64'($urandom_range(0, 65536));
   endfunction

   function automatic sesg_item_type make_edge(input logic [15:0] sslot, islot,
                                               input logic [63:0] edge_id, src, dst, ident);
      sesg_item_type item;
      item.source_slot    = sslot;
      item.identity_slot  = islot;
      item.edge_ident     = edge_id;
      item.src_node       = src;
      item.dst_node       = dst;
      item.identity_ident = ident;
      gen_src     = src;
      gen_dst     = dst;
      gen_edge    = edge_id;
      gen_ident   = ident;
      gen_started = 1'b1;
      return item;
   endfunction

   function automatic sesg_item_type next_edge();
      sesg_item_type item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (!gen_started || (pick < 35 && gen_src != ALL_ONES)
          || (gen_dst == ALL_ONES && gen_edge == ALL_ONES)) begin
         gen_src  = climb(gen_src, 64'd8);
         gen_dst  = pick_wide();
         gen_edge = pick_wide();
      end else if ((pick < 75 || gen_edge == ALL_ONES) && gen_dst != ALL_ONES) begin
         gen_dst  = climb(gen_dst, 64'd2);
         gen_edge = pick_wide();
      end else begin
         gen_edge = climb(gen_edge, 64'd2);
      end
      gen_started = 1'b1;
      gen_ident = climb(gen_ident, 64'd8);
      item.source_slot    = 16'($urandom_range(0, cfg_total - 1));
      item.identity_slot  = 16'($urandom_range(0, cfg_total - 1));
      item.edge_ident     = gen_edge;
      item.src_node       = gen_src;
      item.dst_node       = gen_dst;
      item.identity_ident = gen_ident;
      return item;
   endfunction

   function automatic record_type make_record(input logic [1:0] kind, input logic [2:0] status,
                                              input logic [63:0] edge_id, src, dst,
                                              input logic [15:0] owner, pos, grp_begin,
                                              input logic [16:0] grp_len, input logic last);
      record_type rec;
      rec.kind      = kind;
      rec.status    = status;
      rec.edge_id   = edge_id;
      rec.src       = src;
      rec.dst       = dst;
      rec.owner     = owner;
      rec.pos       = pos;
      rec.grp_begin = grp_begin;
      rec.grp_len   = grp_len;
      rec.last      = last;
      return rec;
   endfunction

   task automatic flag_status(input logic [2:0] code);
      err_code = code;
      record_q.push_back(make_record(KIND_STATUS, code, '0, '0, '0, '0, '0, '0, '0, 1'b1));
   endtask

   task automatic group_edge(input sesg_item_type item);
      logic [16:0] pos;
      logic [17:0] owners_after;
      logic        new_run;
      logic        final_item;
      logic        less;
      if (err_code != ST_OK) return;
      if (cfg_total == 17'd0 || cfg_total > MAX_EDGES || cfg_forward == '0
          || cfg_transpose == '0 || cfg_forward == cfg_transpose) begin
         flag_status(ST_BAD_ARG);
         return;
      end
      if (pos_count >= cfg_total) return;
      pos = pos_count;
      if (item.source_slot >= cfg_total || item.identity_slot >= cfg_total) begin
         flag_status(ST_BAD_ORD);
         return;
      end
      if (item.edge_ident == '0 || item.src_node == '0 || item.dst_node == '0) begin
         flag_status(ST_BAD_ARG);
         return;
      end
      if (pos != 17'd0) begin
         if (last_src != item.src_node) less = last_src < item.src_node;
         else if (last_dst != item.dst_node) less = last_dst < item.dst_node;
         else less = last_edge < item.edge_ident;
         if (!less) begin
            flag_status(last_edge == item.edge_ident ? ST_DUP_ID : ST_BAD_ORD);
            return;
         end
         if (last_ident >= item.identity_ident) begin
            flag_status(last_ident == item.identity_ident ? ST_DUP_ID : ST_BAD_ORD);
            return;
         end
      end
      new_run      = (pos == 17'd0) || (last_src != item.src_node);
      final_item   = (pos + 17'd1 == cfg_total);
      owners_after = owner_tally + new_run;
      if (final_item && (cfg_total > cfg_place_room || owners_after > cfg_owner_room)) begin
         flag_status(ST_CAPACITY);
         return;
      end
      if (new_run && pos != 17'd0)
         record_q.push_back(make_record(KIND_OWNER, ST_OK, '0, last_src, '0,
                                        16'(owner_tally - 1), '0, run_begin, run_len, 1'b0));
      if (new_run) begin
         run_begin   = pos[15:0];
         run_len     = '0;
         owner_tally = owners_after[16:0];
      end
      run_len = run_len + 17'd1;
      record_q.push_back(make_record(KIND_PLACE, ST_OK, item.edge_ident, item.src_node,
                                     item.dst_node, 16'(owner_tally - 1), pos[15:0],
                                     '0, '0, 1'b0));
      if (final_item)
         record_q.push_back(make_record(KIND_OWNER, ST_OK, '0, item.src_node, '0,
                                        16'(owner_tally - 1), '0, run_begin, run_len, 1'b1));
      last_src   = item.src_node;
      last_dst   = item.dst_node;
      last_edge  = item.edge_ident;
      last_ident = item.identity_ident;
      pos_count  = pos + 17'd1;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fault_count++;
      end
   endtask

   task automatic program_reg(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         REG_EDGE_TOTAL:     cfg_total      = value[16:0];
         REG_FORWARD_ID:     cfg_forward    = value;
         REG_TRANSPOSE_ID:   cfg_transpose  = value;
         REG_PLACEMENT_ROOM: cfg_place_room = value[16:0];
         REG_OWNER_ROOM:     cfg_owner_room = value[16:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // hold until every queued edge is taken and every record has arrived
   task automatic settle();
      while (stimulus_q.size() != 0 || offering || record_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (!offering && stimulus_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            offer_item = stimulus_q.pop_front();
            offering   = 1'b1;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
      req_tvalid <= offering;
      req_tdata  <= offer_item;
   end

   always @(posedge clock) begin
      sesg_rsp_type got;
      record_type   want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            group_edge(sesg_item_type'(req_tdata));
            offering = 1'b0;
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = sesg_rsp_type'(rsp_tdata);
            result_count++;
            if (rsp_tuser == KIND_PLACE) place_rec_count++;
            if (rsp_tuser == KIND_OWNER) owner_rec_count++;
            if (record_q.size() == 0) begin
               $error("result transfer with nothing expected: kind %0d status %0d",
                      rsp_tuser, got.status);
               fault_count++;
            end else begin
               want = record_q.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("status", want.status, got.status);
               check_field("out_edge", want.edge_id, got.out_edge);
               check_field("out_source", want.src, got.out_source);
               check_field("out_dest", want.dst, got.out_dest);
               check_field("owner_number", want.owner, got.owner_number);
               check_field("out_position", want.pos, got.out_position);
               check_field("group_begin", want.grp_begin, got.group_begin);
               check_field("group_length", want.grp_len, got.group_length);
               check_field("last", want.last, rsp_tlast);
               check_field("pad", '0, got.pad);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d records outstanding",
                cycle_count, record_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      ending_type    ending;
      int unsigned   pick;
      int unsigned   mix;
      sesg_item_type item;
      logic [63:0]   fwd;
      logic [63:0]   trn;
      logic [63:0]   keep_src;
      logic [63:0]   keep_dst;
      logic [63:0]   keep_edge;
      logic [63:0]   keep_ident;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      program_reg(REG_FORWARD_ID, ALL_ONES);
      program_reg(REG_TRANSPOSE_ID, 64'd1);
      program_reg(REG_EDGE_TOTAL, 64'd65536);
      program_reg(REG_PLACEMENT_ROOM, 64'd65536);
      program_reg(REG_OWNER_ROOM, 64'd65536);
      stimulus_q.push_back(make_edge(16'd0, 16'd0, 64'd1, 64'd1, 64'd1, 64'd1));
      stimulus_q.push_back(make_edge(16'hFFFF, 16'hFFFF, 64'd2, 64'd1, 64'd1, 64'd2));
      stimulus_q.push_back(make_edge(16'd1, 16'hFFFE, ALL_ONES, 64'd1, ALL_ONES, 64'd3));
      stimulus_q.push_back(make_edge(16'h8000, 16'h7FFF, 64'd1, 64'd2, 64'd1, 64'd4));
      repeat (16) stimulus_q.push_back(next_edge());
      settle();

      // drop edge_total to the current position: edges are ignored, then resume
      program_reg(REG_EDGE_TOTAL, 64'(pos_count));
      repeat (3) stimulus_q.push_back(next_edge());
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         program_reg(REG_EDGE_TOTAL, (phase == 0) ? 64'd65536
                     : 64'($urandom_range(pos_count + PHASE_ITEMS + 1, 65536)));
         fwd = pick_wide();
         trn = pick_wide();
         if (trn == fwd) trn = (fwd == ALL_ONES) ? 64'd1 : ALL_ONES;
         program_reg(REG_FORWARD_ID, fwd);
         program_reg(REG_TRANSPOSE_ID, trn);
         program_reg(REG_PLACEMENT_ROOM, room_value());
         program_reg(REG_OWNER_ROOM, room_value());
         send_idle_pct  = send_pct_tab[phase];
         recv_stall_pct = recv_pct_tab[phase];
         repeat (PHASE_ITEMS) stimulus_q.push_back(next_edge());
         settle();
      end

      ending = ending_type'($urandom_range(0, 6));
      pick   = $urandom_range(0, 4);
      mix    = $urandom_range(0, 3);
      send_idle_pct  = send_pct_tab[mix];
      recv_stall_pct = recv_pct_tab[mix];
      keep_src   = gen_src;
      keep_dst   = gen_dst;
      keep_edge  = gen_edge;
      keep_ident = gen_ident;
      case (ending)
         END_FINAL: begin
            program_reg(REG_EDGE_TOTAL, 64'(pos_count + 1));
            program_reg(REG_PLACEMENT_ROOM, (pick % 2 == 0) ? 64'(pos_count + 1) : 64'd65536);
            program_reg(REG_OWNER_ROOM, 64'(owner_tally + 1));
            item = next_edge();
         end
         END_CAPACITY: begin
            program_reg(REG_EDGE_TOTAL, 64'(pos_count + 1));
            if (pick % 2 == 0)
               program_reg(REG_PLACEMENT_ROOM, 64'($urandom_range(0, pos_count)));
            else
               program_reg(REG_OWNER_ROOM, (pick == 1) ? 64'd0 : 64'(owner_tally - 1));
            item = next_edge();
         end
         END_BAD_REG: begin
            case (pick)
               0: program_reg(REG_EDGE_TOTAL, 64'd0);
               1: program_reg(REG_EDGE_TOTAL, 64'($urandom_range(65537, 131071)));
               2: program_reg(REG_FORWARD_ID, 64'd0);
               3: program_reg(REG_TRANSPOSE_ID, 64'd0);
               default: program_reg(REG_TRANSPOSE_ID, cfg_forward);
            endcase
            item = next_edge();
         end
         END_SLOT: begin
            program_reg(REG_EDGE_TOTAL, 64'($urandom_range(pos_count + 1, 65535)));
            item = next_edge();
            if (pick % 2 == 0) item.source_slot = 16'($urandom_range(cfg_total, 65535));
            else item.identity_slot = 16'($urandom_range(cfg_total, 65535));
         end
         END_ZERO: begin
            item = next_edge();
            case (pick % 3)
               0: item.edge_ident = '0;
               1: item.src_node   = '0;
               default: item.dst_node = '0;
            endcase
         end
         END_ORDER: begin
            item = next_edge();
            case (pick % 4)
               0: item.src_node = keep_src - 64'd1;
               1: begin
                  item.src_node   = keep_src;
                  item.dst_node   = keep_dst;
                  item.edge_ident = keep_edge;
               end
               2: begin
                  item.src_node   = keep_src;
                  item.dst_node   = keep_dst;
                  item.edge_ident = keep_edge - 64'd1;
               end
               default: begin
                  item.src_node   = keep_src - 64'd1;
                  item.edge_ident = keep_edge;
               end
            endcase
         end
         default: begin
            item = next_edge();
            item.identity_ident = (pick % 2 == 0) ? keep_ident : keep_ident - 64'd1;
         end
      endcase
      stimulus_q.push_back(item);
      // trailing edges after the stream has closed
      repeat (5) stimulus_q.push_back(next_edge());
      settle();

      if (record_q.size() != 0) begin
         $error("%0d expected records never arrived", record_q.size());
         fault_count++;
      end
      $display("Streamed %0d edges, checked %0d records (%0d placements, %0d owners).",
               accepted_count, result_count, place_rec_count, owner_rec_count);
      $display("Stream closed by %s after four register settings and idle mixes.",
               ending.name());
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
